>>> sv/lprl_pkg.sv
// Shared constants and types for the longest-prefix route lookup block.
`default_nettype none

package lprl_pkg;

    localparam int unsigned ROUTE_ENTRIES_DEF = 256;
    localparam int unsigned PORT_BITS_DEF     = 4;

    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned IDX_W      = 8;
    localparam int unsigned OUT_PORT_W = 4;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Control bits that travel with each beat along the cell chain.
    // For a lookup, flag means a route has matched so far; for a write,
    // flag is the valid bit to store.
    typedef struct packed {
        logic valid;
        logic lookup;
        logic flag;
    } lprl_ctl_t;

endpackage

`default_nettype wire

>>> sv/lprl_cell.sv
// One route slot of the lookup chain with its hand-off register to the next slot.
`default_nettype none

module lprl_cell
    import lprl_pkg::*;
#(
    parameter int unsigned PORT_BITS  = PORT_BITS_DEF,
    parameter int unsigned CELL_INDEX = 0
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 advance,
    input  wire lprl_ctl_t            ctl_in,
    input  wire logic [IDX_W-1:0]     idx_in,
    input  wire logic [ADDR_W-1:0]    addr_in,
    input  wire logic [ADDR_W-1:0]    mask_in,
    input  wire logic [ADDR_W-1:0]    hop_in,
    input  wire logic [PORT_BITS-1:0] port_in,
    output lprl_ctl_t                 ctl_out,
    output logic [IDX_W-1:0]          idx_out,
    output logic [ADDR_W-1:0]         addr_out,
    output logic [ADDR_W-1:0]         mask_out,
    output logic [ADDR_W-1:0]         hop_out,
    output logic [PORT_BITS-1:0]      port_out
);

    localparam logic [ADDR_W-1:0] CellIdx = ADDR_W'(CELL_INDEX);

    logic                 ent_valid_reg;
    logic                 ent_valid_next;
    logic [ADDR_W-1:0]    ent_prefix_reg;
    logic [ADDR_W-1:0]    ent_mask_reg;
    logic [ADDR_W-1:0]    ent_hop_reg;
    logic [PORT_BITS-1:0] ent_port_reg;

    lprl_ctl_t            ctl_reg;
    lprl_ctl_t            ctl_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [ADDR_W-1:0]    mask_reg;
    logic [ADDR_W-1:0]    mask_next;
    logic [ADDR_W-1:0]    hop_reg;
    logic [ADDR_W-1:0]    hop_next;
    logic [PORT_BITS-1:0] port_reg;
    logic [PORT_BITS-1:0] port_next;

    logic                 slot_write;
    logic                 slot_match;
    logic                 slot_better;

    always_comb begin
        slot_write  = advance && ctl_in.valid && !ctl_in.lookup
                      && ({{(ADDR_W-IDX_W){1'b0}}, idx_in} == CellIdx);
        slot_match  = ent_valid_reg
                      && ((addr_in & ent_mask_reg) == (ent_prefix_reg & ent_mask_reg));
        slot_better = ctl_in.lookup && slot_match
                      && (!ctl_in.flag || (ent_mask_reg > mask_in));

        ent_valid_next = slot_write ? ctl_in.flag : ent_valid_reg;

        ctl_next  = ctl_in;
        mask_next = mask_in;
        hop_next  = hop_in;
        port_next = port_in;
        if (slot_better) begin
            ctl_next.flag = 1'b1;
            mask_next     = ent_mask_reg;
            hop_next      = ent_hop_reg;
            port_next     = ent_port_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= 1'b0;
        end else begin
            ent_valid_reg <= ent_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_write) begin
            ent_prefix_reg <= addr_in;
            ent_mask_reg   <= mask_in;
            ent_hop_reg    <= hop_in;
            ent_port_reg   <= port_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (advance) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            idx_reg  <= idx_in;
            addr_reg <= addr_in;
            mask_reg <= mask_next;
            hop_reg  <= hop_next;
            port_reg <= port_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign idx_out  = idx_reg;
    assign addr_out = addr_reg;
    assign mask_out = mask_reg;
    assign hop_out  = hop_reg;
    assign port_out = port_reg;

endmodule

`default_nettype wire

>>> sv/longest_prefix_route_lookup.sv
// Top level of the IPv4 longest-prefix route lookup: a chain of route slot cells.
`default_nettype none

// Every beat, write or lookup, walks a chain of ROUTE_ENTRIES cells, one cell
// per cycle while the chain advances, and leaves the last cell as the result
// beat. A new beat is accepted in every cycle while results are taken; the
// chain of cells sets that figure, and a stalled result holds the whole
// chain, with s_ready low, until m_ready.
// Beats stay in order, so a lookup always sees every write accepted before it.
// Each cell holds one route slot; a write stores its slot as it passes, and a
// lookup carries the best match so far, replaced only by a strictly larger
// mask, so equal masks resolve to the lowest slot. Reset clears all slots.
module longest_prefix_route_lookup
    import lprl_pkg::*;
#(
    parameter int unsigned ROUTE_ENTRIES = ROUTE_ENTRIES_DEF,
    parameter int unsigned PORT_BITS     = PORT_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_cmd,
    input  wire logic [IDX_W-1:0]      s_entry_index,
    input  wire logic [ADDR_W-1:0]     s_entry_prefix,
    input  wire logic [ADDR_W-1:0]     s_entry_mask,
    input  wire logic [ADDR_W-1:0]     s_entry_gateway,
    input  wire logic [OUT_PORT_W-1:0] s_entry_port,
    input  wire logic                  s_entry_valid,
    input  wire logic [ADDR_W-1:0]     s_dest_addr,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_is_lookup,
    output logic                       m_hit,
    output logic [ADDR_W-1:0]          m_gateway,
    output logic [OUT_PORT_W-1:0]      m_port
);

    lprl_ctl_t            ctl_chain  [0:ROUTE_ENTRIES];
    logic [IDX_W-1:0]     idx_chain  [0:ROUTE_ENTRIES];
    logic [ADDR_W-1:0]    addr_chain [0:ROUTE_ENTRIES];
    logic [ADDR_W-1:0]    mask_chain [0:ROUTE_ENTRIES];
    logic [ADDR_W-1:0]    hop_chain  [0:ROUTE_ENTRIES];
    logic [PORT_BITS-1:0] port_chain [0:ROUTE_ENTRIES];

    logic                 advance;
    logic                 in_lookup;
    logic [PORT_BITS-1:0] in_port;
    lprl_ctl_t            out_ctl;
    logic [OUT_PORT_W-1:0] out_port;

    assign out_ctl = ctl_chain[ROUTE_ENTRIES];
    assign m_valid = out_ctl.valid;
    assign advance = !out_ctl.valid || m_ready;
    assign s_ready = advance;

    assign in_lookup = (s_cmd == CMD_LOOKUP);

    for (genvar b = 0; b < PORT_BITS; b++) begin : g_in_port
        if (b < OUT_PORT_W) begin : g_bit
            assign in_port[b] = s_entry_port[b];
        end else begin : g_zero
            assign in_port[b] = 1'b0;
        end
    end

    for (genvar b = 0; b < OUT_PORT_W; b++) begin : g_out_port
        if (b < PORT_BITS) begin : g_bit
            assign out_port[b] = port_chain[ROUTE_ENTRIES][b];
        end else begin : g_zero
            assign out_port[b] = 1'b0;
        end
    end

    always_comb begin
        ctl_chain[0].valid  = s_valid;
        ctl_chain[0].lookup = in_lookup;
        ctl_chain[0].flag   = in_lookup ? 1'b0 : s_entry_valid;
        idx_chain[0]        = s_entry_index;
        addr_chain[0]       = in_lookup ? s_dest_addr : s_entry_prefix;
        mask_chain[0]       = in_lookup ? '0 : s_entry_mask;
        hop_chain[0]        = in_lookup ? '0 : s_entry_gateway;
        port_chain[0]       = in_lookup ? '0 : in_port;
    end

    for (genvar i = 0; i < ROUTE_ENTRIES; i++) begin : g_cell
        lprl_cell #(
            .PORT_BITS  (PORT_BITS),
            .CELL_INDEX (i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .ctl_in   (ctl_chain[i]),
            .idx_in   (idx_chain[i]),
            .addr_in  (addr_chain[i]),
            .mask_in  (mask_chain[i]),
            .hop_in   (hop_chain[i]),
            .port_in  (port_chain[i]),
            .ctl_out  (ctl_chain[i+1]),
            .idx_out  (idx_chain[i+1]),
            .addr_out (addr_chain[i+1]),
            .mask_out (mask_chain[i+1]),
            .hop_out  (hop_chain[i+1]),
            .port_out (port_chain[i+1])
        );
    end

    always_comb begin
        m_is_lookup = out_ctl.lookup;
        m_hit       = out_ctl.lookup && out_ctl.flag;
        m_gateway   = m_hit ? hop_chain[ROUTE_ENTRIES] : '0;
        m_port      = m_hit ? out_port : '0;
    end

endmodule

`default_nettype wire

>>> sv/lprl_checker.sv
// Port-level checker for the route lookup block, bound to the top level.
`default_nettype none

module lprl_checker
    import lprl_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic                  m_is_lookup,
    input wire logic                  m_hit,
    input wire logic [ADDR_W-1:0]     m_gateway,
    input wire logic [OUT_PORT_W-1:0] m_port
);

    // A stalled result beat holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_lookup) && $stable(m_hit)
                                && $stable(m_gateway) && $stable(m_port))
    else $error("result beat changed while stalled");

    // A stalled result freezes the chain, so no input beat can enter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
    else $error("input accepted while the result is stalled");

    // A write acknowledge never reports a route.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_lookup |-> !m_hit)
    else $error("write acknowledge reports a hit");

    // A miss carries zero next hop and port.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> (m_gateway == '0) && (m_port == '0))
    else $error("miss carries a nonzero next hop or port");

    // Reset empties the chain.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
    else $error("result beat valid right after reset");

endmodule

bind longest_prefix_route_lookup lprl_checker u_lprl_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_is_lookup (m_is_lookup),
    .m_hit       (m_hit),
    .m_gateway   (m_gateway),
    .m_port      (m_port)
);

`default_nettype wire

>>> dv/route_lookup_checker.sv
// Passive checker for the longest-prefix route lookup: predicts every result beat and compares.
`timescale 1ns / 1ps

module route_lookup_checker
    import lprl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [IDX_W-1:0]      s_entry_index,
    input  logic [ADDR_W-1:0]     s_entry_prefix,
    input  logic [ADDR_W-1:0]     s_entry_mask,
    input  logic [ADDR_W-1:0]     s_entry_gateway,
    input  logic [OUT_PORT_W-1:0] s_entry_port,
    input  logic                  s_entry_valid,
    input  logic [ADDR_W-1:0]     s_dest_addr,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_is_lookup,
    input  logic                  m_hit,
    input  logic [ADDR_W-1:0]     m_gateway,
    input  logic [OUT_PORT_W-1:0] m_port,
    output int                    mismatches,
    output int                    pending,
    output int                    lookup_total,
    output int                    hit_total
);

    typedef struct packed {
        logic                  is_lookup;
        logic                  hit;
        logic [ADDR_W-1:0]     gateway;
        logic [OUT_PORT_W-1:0] port;
    } route_answer_t;

    logic [ADDR_W-1:0]     tbl_prefix [ROUTE_ENTRIES_DEF];
    logic [ADDR_W-1:0]     tbl_mask   [ROUTE_ENTRIES_DEF];
    logic [ADDR_W-1:0]     tbl_hop    [ROUTE_ENTRIES_DEF];
    logic [OUT_PORT_W-1:0] tbl_port   [ROUTE_ENTRIES_DEF];
    logic                  tbl_active [ROUTE_ENTRIES_DEF];

    route_answer_t awaited_answers[$];
    int            bad_fields;
    int            n_lookups;
    int            n_hits;

    initial begin
        mismatches   = 0;
        pending      = 0;
        lookup_total = 0;
        hit_total    = 0;
        bad_fields   = 0;
        n_lookups    = 0;
        n_hits       = 0;
    end

    function automatic route_answer_t route_answer(
        input logic                  cmd,
        input logic [IDX_W-1:0]      idx,
        input logic [ADDR_W-1:0]     prefix,
        input logic [ADDR_W-1:0]     mask,
        input logic [ADDR_W-1:0]     hop,
        input logic [OUT_PORT_W-1:0] port,
        input logic                  active,
        input logic [ADDR_W-1:0]     dest
    );
        route_answer_t     ans;
        logic              found;
        logic [ADDR_W-1:0] best_mask;
        int                best;
        ans       = '0;
        found     = 1'b0;
        best_mask = '0;
        best      = 0;
        if (cmd == CMD_WRITE) begin
            if (idx < ROUTE_ENTRIES_DEF) begin
                tbl_prefix[idx] = prefix;
                tbl_mask[idx]   = mask;
                tbl_hop[idx]    = hop;
                tbl_port[idx]   = port;
                tbl_active[idx] = active;
            end
            return ans;
        end
        for (int i = 0; i < ROUTE_ENTRIES_DEF; i++) begin
            if (tbl_active[i] && ((dest & tbl_mask[i]) == (tbl_prefix[i] & tbl_mask[i]))
                    && (!found || tbl_mask[i] > best_mask)) begin
                found     = 1'b1;
                best_mask = tbl_mask[i];
                best      = i;
            end
        end
        ans.is_lookup = 1'b1;
        n_lookups++;
        if (found) begin
            ans.hit     = 1'b1;
            ans.gateway = tbl_hop[best];
            ans.port    = tbl_port[best];
            n_hits++;
        end
        return ans;
    endfunction

    task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            bad_fields++;
        end
    endtask

    always @(posedge aclk) begin
        route_answer_t want;
        if (!aresetn) begin
            for (int i = 0; i < ROUTE_ENTRIES_DEF; i++) tbl_active[i] = 1'b0;
            awaited_answers.delete();
        end else begin
            if (s_valid && s_ready) begin
                awaited_answers.push_back(route_answer(s_cmd, s_entry_index, s_entry_prefix,
                    s_entry_mask, s_entry_gateway, s_entry_port, s_entry_valid,
                    s_dest_addr));
            end
            if (m_valid && m_ready) begin
                if (awaited_answers.size() == 0) begin
                    $error("result beat arrived with no beat outstanding");
                    bad_fields++;
                end else begin
                    want = awaited_answers.pop_front();
                    check_field("is_lookup", want.is_lookup, m_is_lookup);
                    check_field("hit", want.hit, m_hit);
                    check_field("gateway", want.gateway, m_gateway);
                    check_field("port", want.port, m_port);
                end
            end
        end
        mismatches   <= bad_fields;
        pending      <= awaited_answers.size();
        lookup_total <= n_lookups;
        hit_total    <= n_hits;
    end

endmodule

>>> dv/tb_longest_prefix_route_lookup.sv
// Testbench top for the longest-prefix route lookup: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_longest_prefix_route_lookup;
    import lprl_pkg::*;

    localparam int RANDOM_BEATS = 2000;
    localparam int HOLD_AT      = 500;
    localparam int DRAIN_AT     = 1200;
    localparam int QUIET_FROM   = 1700;
    localparam int HOLD_CYCLES  = 700;
    localparam int TAIL_CYCLES  = 300;
    localparam int NUM_BASES    = 6;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_cmd;
    logic [IDX_W-1:0]      s_entry_index;
    logic [ADDR_W-1:0]     s_entry_prefix;
    logic [ADDR_W-1:0]     s_entry_mask;
    logic [ADDR_W-1:0]     s_entry_gateway;
    logic [OUT_PORT_W-1:0] s_entry_port;
    logic                  s_entry_valid;
    logic [ADDR_W-1:0]     s_dest_addr;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_is_lookup;
    logic                  m_hit;
    logic [ADDR_W-1:0]     m_gateway;
    logic [OUT_PORT_W-1:0] m_port;

    int mismatches;
    int pending;
    int lookup_total;
    int hit_total;

    logic              hold_req;
    logic              quiet;
    int                beats_sent;
    logic [ADDR_W-1:0] net_base [NUM_BASES];

    longest_prefix_route_lookup dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_cmd(s_cmd), .s_entry_index(s_entry_index), .s_entry_prefix(s_entry_prefix),
        .s_entry_mask(s_entry_mask), .s_entry_gateway(s_entry_gateway),
        .s_entry_port(s_entry_port), .s_entry_valid(s_entry_valid),
        .s_dest_addr(s_dest_addr),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_is_lookup(m_is_lookup), .m_hit(m_hit), .m_gateway(m_gateway), .m_port(m_port)
    );

    route_lookup_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_cmd(s_cmd), .s_entry_index(s_entry_index), .s_entry_prefix(s_entry_prefix),
        .s_entry_mask(s_entry_mask), .s_entry_gateway(s_entry_gateway),
        .s_entry_port(s_entry_port), .s_entry_valid(s_entry_valid),
        .s_dest_addr(s_dest_addr),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_is_lookup(m_is_lookup), .m_hit(m_hit), .m_gateway(m_gateway), .m_port(m_port),
        .mismatches(mismatches), .pending(pending),
        .lookup_total(lookup_total), .hit_total(hit_total)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    initial begin
        #4_000_000;
        $display("** longest_prefix_route_lookup: FAILED **");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] prefix_mask(input int unsigned len);
        return ~({ADDR_W{1'b1}} >> len);
    endfunction

    task automatic put_beat(
        input logic                  cmd,
        input logic [IDX_W-1:0]      idx,
        input logic [ADDR_W-1:0]     prefix,
        input logic [ADDR_W-1:0]     mask,
        input logic [ADDR_W-1:0]     hop,
        input logic [OUT_PORT_W-1:0] port,
        input logic                  active,
        input logic [ADDR_W-1:0]     dest
    );
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_cmd            <= cmd;
        s_entry_index    <= idx;
        s_entry_prefix   <= prefix;
        s_entry_mask     <= mask;
        s_entry_gateway  <= hop;
        s_entry_port     <= port;
        s_entry_valid    <= active;
        s_dest_addr      <= dest;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic write_route(
        input logic [IDX_W-1:0]      idx,
        input logic [ADDR_W-1:0]     prefix,
        input logic [ADDR_W-1:0]     mask,
        input logic [ADDR_W-1:0]     hop,
        input logic [OUT_PORT_W-1:0] port,
        input logic                  active
    );
        put_beat(CMD_WRITE, idx, prefix, mask, hop, port, active, $urandom);
    endtask

    task automatic lookup_route(input logic [ADDR_W-1:0] dest);
        put_beat(CMD_LOOKUP, IDX_W'($urandom), $urandom, $urandom, $urandom,
                 OUT_PORT_W'($urandom), 1'($urandom), dest);
    endtask

    task automatic random_beat();
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] prefix;
        base = net_base[$urandom_range(0, NUM_BASES - 1)];
        if ($urandom_range(0, 9) < 3) begin
            if ($urandom_range(0, 9) == 0) mask = $urandom;
            else if ($urandom_range(0, 39) == 0) mask = '0;
            else mask = prefix_mask($urandom_range(4, 32));
            prefix = ($urandom_range(0, 9) == 0) ? $urandom : base ^ ($urandom & ~mask);
            write_route(IDX_W'($urandom_range(0, 255)), prefix, mask, $urandom,
                        OUT_PORT_W'($urandom_range(0, 15)), $urandom_range(0, 7) != 0);
        end else begin
            case ($urandom_range(0, 9))
                0: lookup_route($urandom);
                1: lookup_route({ADDR_W{$urandom_range(0, 1) == 1}});
                default: lookup_route(base ^ ($urandom & ({ADDR_W{1'b1}}
                                                          >> $urandom_range(0, 32))));
            endcase
        end
    endtask

    // The receiver side: short random stalls, one long hold-off on request, none at the end.
    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_cmd            <= CMD_WRITE;
        s_entry_index    <= '0;
        s_entry_prefix   <= '0;
        s_entry_mask     <= '0;
        s_entry_gateway  <= '0;
        s_entry_port     <= '0;
        s_entry_valid    <= 1'b0;
        s_dest_addr      <= '0;
        hold_req         <= 1'b0;
        quiet            <= 1'b0;
        beats_sent = 0;
        for (int i = 0; i < NUM_BASES; i++) net_base[i] = $urandom;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: empty table, default route, nested routes, ties, cleared slots.
        lookup_route('0);
        write_route(8'd0, 32'h1234_5678, '0, 32'hFFFF_FFFF, 4'd15, 1'b1);
        lookup_route(32'hFFFF_FFFF);
        write_route(8'd255, 32'h0A00_0000, prefix_mask(8), 32'h0A00_00FE, 4'd1, 1'b1);
        write_route(8'd10, 32'h0A01_0000, prefix_mask(16), 32'hC0A8_0001, 4'd2, 1'b1);
        write_route(8'd20, 32'h0A01_0203, prefix_mask(32), 32'h0000_0000, 4'd0, 1'b1);
        lookup_route(32'h0A01_0203);
        lookup_route(32'h0A01_0204);
        lookup_route(32'h0A7F_0000);
        write_route(8'd30, 32'h0A01_FFFF, prefix_mask(16), 32'hC0A8_0002, 4'd4, 1'b1);
        lookup_route(32'h0A01_55AA);
        write_route(8'd5, 32'h0A01_0000, prefix_mask(16), 32'hC0A8_0003, 4'd5, 1'b1);
        lookup_route(32'h0A01_55AA);
        write_route(8'd5, 32'h0A01_0000, prefix_mask(16), 32'hC0A8_0003, 4'd5, 1'b0);
        lookup_route(32'h0A01_55AA);
        write_route(8'd40, 32'hA0B0_C0D0, 32'hF0F0_F0F0, 32'h5555_AAAA, 4'd6, 1'b1);
        lookup_route(32'hA5B5_C5D5);
        write_route(8'd0, 32'h1234_5678, '0, 32'hFFFF_FFFF, 4'd15, 1'b0);
        lookup_route(32'h1234_5678);
        lookup_route(32'h0B00_0001);
        write_route(8'd0, 32'hFFFF_FFFF, prefix_mask(1), 32'hAAAA_5555, 4'd9, 1'b1);
        lookup_route(32'hFFFF_FFFF);
        lookup_route(32'h7FFF_FFFF);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == HOLD_AT) hold_req <= 1'b1;
            if (n == QUIET_FROM) quiet <= 1'b1;
            if (n == DRAIN_AT) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending != 0);
            end
            random_beat();
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d beats: %0d route writes and %0d lookups, %0d of them hits.",
                 beats_sent, beats_sent - lookup_total, lookup_total, hit_total);
        $display("Included a %0d-cycle result hold-off and a full drain mid-run.",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending == 0) begin
            $display("** longest_prefix_route_lookup: PASSED **");
        end else begin
            $display("** longest_prefix_route_lookup: FAILED **");
        end
        $finish;
    end

endmodule
